[hdl/brm_pkg.sv]
// ----------------------------------------------------------------------------
// brm_pkg
// Shared types and codes for the banked ROM mapper: action codes, register
// decode codes, emission positions and the controller/datapath interface.
// ----------------------------------------------------------------------------
package brm_pkg;

  // Action codes of an input word
  localparam logic [1:0] ACT_WRITE  = 2'd0;
  localparam logic [1:0] ACT_TICK   = 2'd1;
  localparam logic [1:0] ACT_REPORT = 2'd2;

  // Register decode: {address[14:13], address[0]} with address[15] set
  localparam logic [2:0] REG_BANK_SEL   = 3'b000;
  localparam logic [2:0] REG_BANK_DATA  = 3'b001;
  localparam logic [2:0] REG_MIRROR     = 3'b010;
  localparam logic [2:0] REG_UNUSED     = 3'b011;
  localparam logic [2:0] REG_IRQ_COUNT  = 3'b100;
  localparam logic [2:0] REG_IRQ_RELOAD = 3'b101;
  localparam logic [2:0] REG_IRQ_OFF    = 3'b110;
  localparam logic [2:0] REG_IRQ_ON     = 3'b111;

  // Configuration register indexes
  localparam logic CFG_PRG_COUNT   = 1'b0;
  localparam logic CFG_FOUR_SCREEN = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_PRG    = 2'd0;
  localparam logic [1:0] KIND_CHR    = 2'd1;
  localparam logic [1:0] KIND_MIRROR = 2'd2;
  localparam logic [1:0] KIND_IRQ    = 2'd3;

  // Emission positions: 0..3 program slots, 4..11 pattern slots, then singles
  localparam logic [3:0] POS_PRG_FIRST = 4'd0;
  localparam logic [3:0] POS_PRG_LAST  = 4'd3;
  localparam logic [3:0] POS_CHR_FIRST = 4'd4;
  localparam logic [3:0] POS_CHR_LAST  = 4'd11;
  localparam logic [3:0] POS_MIRROR    = 4'd12;
  localparam logic [3:0] POS_IRQ       = 4'd13;

  // Bank selector codes that pick a program register
  localparam logic [2:0] SEL_PRG_0 = 3'd6;

  // State update operations issued by the controller
  typedef enum logic [2:0] {
    OP_NONE,
    OP_BANK_SEL,
    OP_BANK_DATA,
    OP_IRQ_COUNT,
    OP_IRQ_RELOAD,
    OP_IRQ_OFF,
    OP_IRQ_ON,
    OP_TICK
  } brm_op_e;

  typedef struct packed {
    brm_op_e    op;
    logic       emit;
    logic [3:0] pos;
    logic       last;
  } brm_cmd_t;

  typedef struct packed {
    logic [2:0] sel;
    logic       four_screen;
    logic       irq_due;
  } brm_status_t;

endpackage

[hdl/banked_rom_mapper_scanline_irq.sv]
// ----------------------------------------------------------------------------
// banked_rom_mapper_scanline_irq
// Cartridge bank mapper with scanline IRQ counter, top level.
// ----------------------------------------------------------------------------
// A word is taken when start_i is high and busy_o is low. Its results leave
// on strobe_o, one word per cycle, each for exactly one cycle; the receiver
// must take every strobed word as it comes, there is no way to stall it.
// A single word (mirroring or IRQ) appears the cycle after the input is
// taken; a run of slot words starts only after the controller has entered
// its emit state. A bank select write or a mapping report streams twelve
// words (four program slots, then eight pattern slots) and holds busy_o
// until the last of them is issued; a bank data write streams four or
// eight words. Mirroring, IRQ and other register writes and scanline ticks
// give at most one word and do not set busy_o. The slot sequencer in the
// controller walks one slot per cycle through the result register. last_o
// marks the final word of each item. Write the configuration port only
// while busy_o is low and no word is still due.
// ----------------------------------------------------------------------------
module banked_rom_mapper_scanline_irq (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command channel
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  action_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  value_i,
  input  logic        in_vblank_i,
  // result channel
  output logic        strobe_o,
  output logic [1:0]  kind_o,
  output logic [2:0]  slot_o,
  output logic [7:0]  bank_o,
  output logic        last_o,
  // configuration port
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [8:0]  cfg_data_i
);
  import brm_pkg::*;

  brm_cmd_t    cmd;
  brm_status_t status;

  // Decode the word and step through the slots
  brm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .action_i   (action_i),
    .address_i  (address_i),
    .in_vblank_i(in_vblank_i),
    .status_i   (status),
    .busy_o     (busy_o),
    .cmd_o      (cmd)
  );

  // Hold the bank and IRQ state, form each result word
  brm_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .value_i    (value_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .strobe_o   (strobe_o),
    .kind_o     (kind_o),
    .slot_o     (slot_o),
    .bank_o     (bank_o),
    .last_o     (last_o)
  );

endmodule

[hdl/brm_ctrl.sv]
// ----------------------------------------------------------------------------
// brm_ctrl
// Controller: decodes an accepted word and sequences the slot emissions.
// ----------------------------------------------------------------------------
module brm_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [1:0]           action_i,
  input  logic [15:0]          address_i,
  input  logic                 in_vblank_i,
  input  brm_pkg::brm_status_t status_i,
  output logic                 busy_o,
  output brm_pkg::brm_cmd_t    cmd_o
);
  import brm_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EMIT = 1'b1;

  logic       state_q, state_d;
  logic [3:0] pos_q, pos_d;
  logic [3:0] end_q, end_d;
  logic       accept;
  logic [2:0] reg_code;

  assign busy_o   = (state_q == S_EMIT);
  assign accept   = start_i && !busy_o;
  assign reg_code = {address_i[14:13], address_i[0]};

  always_comb begin
    cmd_o   = '{op: OP_NONE, emit: 1'b0, pos: POS_PRG_FIRST, last: 1'b0};
    state_d = state_q;
    pos_d   = pos_q;
    end_d   = end_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (action_i)
            ACT_WRITE: begin
              if (address_i[15]) begin
                unique case (reg_code)
                  REG_BANK_SEL: begin
                    cmd_o.op = OP_BANK_SEL;
                    state_d  = S_EMIT;
                    pos_d    = POS_PRG_FIRST;
                    end_d    = POS_CHR_LAST;
                  end
                  REG_BANK_DATA: begin
                    cmd_o.op = OP_BANK_DATA;
                    state_d  = S_EMIT;
                    if (status_i.sel >= SEL_PRG_0) begin
                      pos_d = POS_PRG_FIRST;
                      end_d = POS_PRG_LAST;
                    end else begin
                      pos_d = POS_CHR_FIRST;
                      end_d = POS_CHR_LAST;
                    end
                  end
                  REG_MIRROR: begin
                    if (!status_i.four_screen) begin
                      cmd_o.emit = 1'b1;
                      cmd_o.pos  = POS_MIRROR;
                      cmd_o.last = 1'b1;
                    end
                  end
                  REG_UNUSED:     cmd_o.op = OP_NONE;
                  REG_IRQ_COUNT:  cmd_o.op = OP_IRQ_COUNT;
                  REG_IRQ_RELOAD: cmd_o.op = OP_IRQ_RELOAD;
                  REG_IRQ_OFF:    cmd_o.op = OP_IRQ_OFF;
                  REG_IRQ_ON:     cmd_o.op = OP_IRQ_ON;
                  default:        cmd_o.op = OP_NONE;
                endcase
              end
            end
            ACT_TICK: begin
              if (!in_vblank_i) begin
                cmd_o.op = OP_TICK;
                if (status_i.irq_due) begin
                  cmd_o.emit = 1'b1;
                  cmd_o.pos  = POS_IRQ;
                  cmd_o.last = 1'b1;
                end
              end
            end
            ACT_REPORT: begin
              state_d = S_EMIT;
              pos_d   = POS_PRG_FIRST;
              end_d   = POS_CHR_LAST;
            end
            default: cmd_o.op = OP_NONE;
          endcase
        end
      end
      S_EMIT: begin
        cmd_o.emit = 1'b1;
        cmd_o.pos  = pos_q;
        cmd_o.last = (pos_q == end_q);
        pos_d      = pos_q + 4'd1;
        if (pos_q == end_q) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pos_q   <= POS_PRG_FIRST;
      end_q   <= POS_PRG_FIRST;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      end_q   <= end_d;
    end
  end

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EMIT |-> pos_q <= end_q && end_q <= POS_CHR_LAST)
    else $error("emission position beyond end of run");

  a_run_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EMIT && pos_q == end_q |=> state_q == S_IDLE)
    else $error("sequencer did not return to idle after last word");

  a_report_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && action_i == ACT_REPORT |=>
      state_q == S_EMIT && pos_q == POS_PRG_FIRST && end_q == POS_CHR_LAST)
    else $error("report did not start a full run");

  a_single_not_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit && (cmd_o.pos == POS_MIRROR || cmd_o.pos == POS_IRQ) |->
      state_q == S_IDLE && cmd_o.last)
    else $error("single word issued inside a run");

endmodule

[hdl/brm_dp.sv]
// ----------------------------------------------------------------------------
// brm_dp
// Datapath: bank, IRQ and configuration registers plus the result register.
// ----------------------------------------------------------------------------
module brm_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_index_i,
  input  logic [8:0]           cfg_data_i,
  input  logic [7:0]           value_i,
  input  brm_pkg::brm_cmd_t    cmd_i,
  output brm_pkg::brm_status_t status_o,
  output logic                 strobe_o,
  output logic [1:0]           kind_o,
  output logic [2:0]           slot_o,
  output logic [7:0]           bank_o,
  output logic                 last_o
);
  import brm_pkg::*;

  logic [8:0] prg_count_q;
  logic       four_screen_q;
  logic [7:0] bank_select_q;
  logic [7:0] prg_q [2];
  logic [7:0] chr_q [8];
  logic       irq_on_q;
  logic [7:0] irq_count_q;
  logic [7:0] irq_reload_q;

  logic       strobe_q;
  logic [1:0] kind_q, kind_d;
  logic [2:0] slot_q, slot_d;
  logic [7:0] bank_q, bank_d;
  logic       last_q;

  logic [2:0] sel;
  logic [7:0] second_last;
  logic [7:0] final_bank;
  logic       prg_swap;
  logic [2:0] chr_slot;
  logic [2:0] chr_idx;

  assign sel         = bank_select_q[2:0];
  assign second_last = prg_count_q[7:0] - 8'd2;
  assign final_bank  = prg_count_q[7:0] - 8'd1;
  assign prg_swap    = bank_select_q[6];
  assign chr_slot    = 3'(cmd_i.pos - POS_CHR_FIRST);
  assign chr_idx     = chr_slot ^ {bank_select_q[7], 2'b00};

  assign status_o = '{sel: sel, four_screen: four_screen_q,
                      irq_due: irq_on_q && (irq_count_q == 8'd0)};

  // Configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_count_q   <= 9'd32;
      four_screen_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PRG_COUNT:   prg_count_q   <= cfg_data_i;
        CFG_FOUR_SCREEN: four_screen_q <= cfg_data_i[0];
        default:         prg_count_q   <= prg_count_q;
      endcase
    end
  end

  // Mapper state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_select_q <= 8'd0;
      prg_q[0]      <= 8'd0;
      prg_q[1]      <= 8'd1;
      for (int i = 0; i < 8; i++) begin
        chr_q[i] <= 8'(i);
      end
      irq_on_q     <= 1'b0;
      irq_count_q  <= 8'd0;
      irq_reload_q <= 8'd0;
    end else begin
      unique case (cmd_i.op)
        OP_BANK_SEL: bank_select_q <= value_i;
        OP_BANK_DATA: begin
          if (sel <= 3'd1) begin
            chr_q[{sel[1:0], 1'b0}] <= {value_i[7:1], 1'b0};
            chr_q[{sel[1:0], 1'b1}] <= {value_i[7:1], 1'b1};
          end else if (sel < SEL_PRG_0) begin
            chr_q[sel + 3'd2] <= value_i;
          end else begin
            prg_q[sel[0]] <= value_i;
          end
        end
        OP_IRQ_COUNT: begin
          irq_count_q <= value_i;
          irq_on_q    <= 1'b1;
        end
        OP_IRQ_RELOAD: irq_reload_q <= value_i;
        OP_IRQ_OFF:    irq_on_q     <= 1'b0;
        OP_IRQ_ON:     irq_on_q     <= 1'b1;
        OP_TICK: begin
          if (irq_on_q) begin
            if (irq_count_q == 8'd0) begin
              irq_count_q <= irq_reload_q;
            end else begin
              irq_count_q <= irq_count_q - 8'd1;
            end
          end
        end
        default: irq_on_q <= irq_on_q;
      endcase
    end
  end

  // Result word for the current emission position
  always_comb begin
    kind_d = KIND_PRG;
    slot_d = 3'd0;
    bank_d = 8'd0;
    if (cmd_i.pos <= POS_PRG_LAST) begin
      slot_d = {1'b0, cmd_i.pos[1:0]};
      unique case (cmd_i.pos[1:0])
        2'd0:    bank_d = prg_swap ? second_last : prg_q[0];
        2'd1:    bank_d = prg_q[1];
        2'd2:    bank_d = prg_swap ? prg_q[0] : second_last;
        default: bank_d = final_bank;
      endcase
    end else if (cmd_i.pos <= POS_CHR_LAST) begin
      kind_d = KIND_CHR;
      slot_d = chr_slot;
      bank_d = chr_q[chr_idx];
    end else if (cmd_i.pos == POS_MIRROR) begin
      kind_d = KIND_MIRROR;
      bank_d = {7'd0, value_i[0]};
    end else begin
      kind_d = KIND_IRQ;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      kind_q <= kind_d;
      slot_q <= slot_d;
      bank_q <= bank_d;
      last_q <= cmd_i.last;
    end
  end

  assign strobe_o = strobe_q;
  assign kind_o   = kind_q;
  assign slot_o   = slot_q;
  assign bank_o   = bank_q;
  assign last_o   = last_q;

endmodule

[bench/banked_rom_mapper_scanline_irq_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// banked_rom_mapper_scanline_irq_tb
// Self-checking bench for the banked ROM mapper. A directed table runs first,
// then four phases of random, mostly well-formed traffic, one mapper setting
// per phase. An item-level shadow of the mapper predicts every result word.
// ----------------------------------------------------------------------------
module banked_rom_mapper_scanline_irq_tb;
  import brm_pkg::*;

  // The action code that the mapper ignores
  localparam logic [1:0] ACT_SPARE    = 2'd3;
  // Bank select bits: program swap, pattern swap, and the pattern slot flip
  localparam int         PRG_SWAP_BIT = 6;
  localparam int         CHR_SWAP_BIT = 7;
  localparam logic [2:0] CHR_FLIP     = 3'd4;
  // A 2K pattern pair always starts on an even bank
  localparam logic [7:0] EVEN_MASK    = 8'hFE;
  // Longest item is a full twelve-word run; wait a little more before going quiet
  localparam int         QUIET_CYCLES = 16;
  localparam int         LIMIT_CYCLES = 200000;
  localparam int         PHASE_ITEMS  = 43;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] slot;
    logic [7:0] bank;
    logic       last;
  } map_word_t;

  // One directed step; a pinned row carries its own result (none or one word)
  typedef struct packed {
    logic [1:0]  act;
    logic [15:0] addr;
    logic [7:0]  val;
    logic        vb;
    logic        pinned;
    logic        n_pin;
    map_word_t   pin;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [1:0]  action_i;
  logic [15:0] address_i;
  logic [7:0]  value_i;
  logic        in_vblank_i;
  logic        strobe_o;
  logic [1:0]  kind_o;
  logic [2:0]  slot_o;
  logic [7:0]  bank_o;
  logic        last_o;
  logic        cfg_we_i;
  logic        cfg_index_i;
  logic [8:0]  cfg_data_i;

  // Shadow of the mapper state and its two settings
  logic [8:0]  sh_prg_count;
  logic        sh_four_screen;
  logic [7:0]  sh_bank_sel;
  logic [7:0]  sh_prg [2];
  logic [7:0]  sh_chr [8];
  logic        sh_irq_on;
  logic [7:0]  sh_irq_count;
  logic [7:0]  sh_irq_reload;

  map_word_t   due_words[$];    // words still owed by the mapper, oldest first
  map_word_t   fresh_words[$];  // words the last predicted item gives
  dir_row_t    dir_tab[$];

  logic        steady;          // set: the sender adds no random gaps between items
  int          err_count;
  int          item_count;
  int          ignored_count;
  int          word_count;
  int          irq_words;
  int unsigned cycle_count;

  banked_rom_mapper_scanline_irq u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .action_i    (action_i),
    .address_i   (address_i),
    .value_i     (value_i),
    .in_vblank_i (in_vblank_i),
    .strobe_o    (strobe_o),
    .kind_o      (kind_o),
    .slot_o      (slot_o),
    .bank_o      (bank_o),
    .last_o      (last_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Guard against a hang: end the run as failed at a generous cycle count
  always @(posedge clk_i) begin
    cycle_count = cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("%0t: timeout, %0d words still owed", $time, due_words.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Shadow model
  // ---------------------------------------------------------------------------
  task automatic push_word(input logic [1:0] kind, input logic [2:0] slot,
                           input logic [7:0] bank);
    map_word_t w;
    w = {kind, slot, bank, 1'b0};
    fresh_words.push_back(w);
  endtask

  // Four 8K program slots; the last bank sits in slot 3, the second last in
  // slot 2 unless the program swap bit trades slot 0 with slot 2
  task automatic emit_prg_slots();
    logic [8:0] second_last;
    logic [8:0] final_bank;
    logic       swap;
    second_last = sh_prg_count - 9'd2;
    final_bank  = sh_prg_count - 9'd1;
    swap        = sh_bank_sel[PRG_SWAP_BIT];
    push_word(KIND_PRG, 3'd0, swap ? second_last[7:0] : sh_prg[0]);
    push_word(KIND_PRG, 3'd1, sh_prg[1]);
    push_word(KIND_PRG, 3'd2, swap ? sh_prg[0] : second_last[7:0]);
    push_word(KIND_PRG, 3'd3, final_bank[7:0]);
  endtask

  // Eight 1K pattern slots; the pattern swap bit flips the two 4K halves
  task automatic emit_chr_slots();
    logic [2:0] flip;
    logic [2:0] s3;
    flip = sh_bank_sel[CHR_SWAP_BIT] ? CHR_FLIP : 3'd0;
    for (int s = 0; s < 8; s++) begin
      s3 = 3'(s);
      push_word(KIND_CHR, s3, sh_chr[s3 ^ flip]);
    end
  endtask

  // Advance the shadow by one accepted item and leave its words in fresh_words
  task automatic map_predict(input logic [1:0] act, input logic [15:0] addr,
                             input logic [7:0] val, input logic vb);
    logic [2:0] reg_code;
    logic [2:0] sel;
    map_word_t  w;
    fresh_words.delete();
    reg_code = {addr[14:13], addr[0]};
    sel      = sh_bank_sel[2:0];
    if (act == ACT_WRITE && addr[15]) begin
      case (reg_code)
        REG_BANK_SEL: begin
          sh_bank_sel = val;
          emit_prg_slots();
          emit_chr_slots();
        end
        REG_BANK_DATA: begin
          if (sel <= 3'd1) begin
            // 2K pair: force the even bank, the odd one follows
            sh_chr[{1'b0, sel[0], 1'b0}] = val & EVEN_MASK;
            sh_chr[{1'b0, sel[0], 1'b1}] = (val & EVEN_MASK) + 8'd1;
            emit_chr_slots();
          end else if (sel < SEL_PRG_0) begin
            sh_chr[sel + 3'd2] = val;
            emit_chr_slots();
          end else begin
            sh_prg[sel[0]] = val;
            emit_prg_slots();
          end
        end
        REG_MIRROR: begin
          if (!sh_four_screen) push_word(KIND_MIRROR, 3'd0, {7'd0, val[0]});
        end
        REG_IRQ_COUNT: begin
          sh_irq_count = val;
          sh_irq_on    = 1'b1;
        end
        REG_IRQ_RELOAD: sh_irq_reload = val;
        REG_IRQ_OFF:    sh_irq_on     = 1'b0;
        REG_IRQ_ON:     sh_irq_on     = 1'b1;
        default: ;
      endcase
    end else if (act == ACT_TICK) begin
      // Count visible lines only; a zero count reloads and raises the IRQ
      if (!vb && sh_irq_on) begin
        if (sh_irq_count == 8'd0) begin
          sh_irq_count = sh_irq_reload;
          push_word(KIND_IRQ, 3'd0, 8'd0);
        end else begin
          sh_irq_count = sh_irq_count - 8'd1;
        end
      end
    end else if (act == ACT_REPORT) begin
      emit_prg_slots();
      emit_chr_slots();
    end
    if (fresh_words.size() > 0) begin
      w      = fresh_words.pop_back();
      w.last = 1'b1;
      fresh_words.push_back(w);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checking: every strobed word must match the oldest owed word
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    map_word_t got;
    map_word_t want;
    if (rst_ni && strobe_o) begin
      got = {kind_o, slot_o, bank_o, last_o};
      if (due_words.size() == 0) begin
        err_count = err_count + 1;
        $display("%0t: unexpected word: expected none, got kind %0d slot %0d bank %0d last %0d",
                 $time, got.kind, got.slot, got.bank, got.last);
      end else begin
        want       = due_words.pop_front();
        word_count = word_count + 1;
        if (want.kind == KIND_IRQ) irq_words = irq_words + 1;
        if (got.kind !== want.kind || got.slot !== want.slot ||
            got.bank !== want.bank || got.last !== want.last) begin
          err_count = err_count + 1;
          $display("%0t: mismatch: expected kind %0d slot %0d bank %0d last %0d, got kind %0d slot %0d bank %0d last %0d",
                   $time, want.kind, want.slot, want.bank, want.last,
                   got.kind, got.slot, got.bank, got.last);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  // Address that decodes to the given register, with random don't-care bits
  function automatic logic [15:0] reg_addr(input logic [2:0] code);
    logic [11:0] mid;
    mid = 12'($urandom);
    return {1'b1, code[2:1], mid, code[0]};
  endfunction

  function automatic dir_row_t mk_row(input logic [1:0] act, input logic [15:0] addr,
                                      input logic [7:0] val, input logic vb,
                                      input logic pinned, input logic n_pin,
                                      input logic [1:0] pin_kind,
                                      input logic [7:0] pin_bank);
    dir_row_t r;
    r.act    = act;
    r.addr   = addr;
    r.val    = val;
    r.vb     = vb;
    r.pinned = pinned;
    r.n_pin  = n_pin;
    r.pin    = {pin_kind, 3'd0, pin_bank, 1'b1};
    return r;
  endfunction

  // Present one word, hold it until taken, then book what it owes
  task automatic send_item(input logic [1:0] act, input logic [15:0] addr,
                           input logic [7:0] val, input logic vb,
                           input logic pinned, input logic n_pin,
                           input map_word_t pin);
    int   gap;
    logic ignored;
    gap = 0;
    if (!steady && $urandom_range(0, 99) < 18) gap = $urandom_range(1, 14);
    @(negedge clk_i);
    if (gap > 0) begin
      start_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    action_i    = act;
    address_i   = addr;
    value_i     = val;
    in_vblank_i = vb;
    start_i     = 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    map_predict(act, addr, val, vb);
    if (pinned) begin
      if (n_pin) due_words.push_back(pin);
    end else begin
      foreach (fresh_words[i]) due_words.push_back(fresh_words[i]);
    end
    ignored = (act == ACT_SPARE) ||
              (act == ACT_WRITE && (!addr[15] || {addr[14:13], addr[0]} == REG_UNUSED));
    if (ignored) ignored_count = ignored_count + 1;
    else item_count = item_count + 1;
  endtask

  task automatic issue(input logic [1:0] act, input logic [15:0] addr,
                       input logic [7:0] val, input logic vb);
    send_item(act, addr, val, vb, 1'b0, 1'b0, '0);
  endtask

  // Drop start and hold off until every owed word has come and the mapper is
  // idle, then let a few more cycles pass for items that give no word
  task automatic wait_quiet();
    @(negedge clk_i);
    start_i = 1'b0;
    while (due_words.size() != 0 || busy_o) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_reg(input logic idx, input logic [8:0] data);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    if (idx == CFG_PRG_COUNT) sh_prg_count = data;
    else sh_four_screen = data[0];
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  initial begin
    logic [8:0]  cnt;
    logic        fs;
    int          goal;
    int          pick;
    int          sub;
    logic [7:0]  v;

    // Drive every input to a known value and hold reset asserted
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    action_i      = ACT_WRITE;
    address_i     = 16'd0;
    value_i       = 8'd0;
    in_vblank_i   = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = CFG_PRG_COUNT;
    cfg_data_i    = 9'd0;
    steady        = 1'b0;
    err_count     = 0;
    item_count    = 0;
    ignored_count = 0;
    word_count    = 0;
    irq_words     = 0;
    cycle_count   = 0;

    sh_prg_count   = 9'd32;
    sh_four_screen = 1'b0;
    sh_bank_sel    = 8'd0;
    sh_prg[0]      = 8'd0;
    sh_prg[1]      = 8'd1;
    for (int i = 0; i < 8; i++) sh_chr[i] = 8'(i);
    sh_irq_on      = 1'b0;
    sh_irq_count   = 8'd0;
    sh_irq_reload  = 8'd0;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table: reset mapping, ignored writes, mirroring, IRQ at zero
    // count and in vertical blank, each bank data path, both swap bits
    dir_tab.push_back(mk_row(ACT_REPORT, 16'h0000, 8'h00, 1'b0, 1'b0, 1'b0, KIND_PRG, 8'd0));
    dir_tab.push_back(mk_row(ACT_WRITE, 16'h7FFF, 8'hFF, 1'b1, 1'b1, 1'b0, KIND_PRG, 8'd0));
    dir_tab.push_back(mk_row(ACT_WRITE, 16'h0000, 8'h00, 1'b0, 1'b1, 1'b0, KIND_PRG, 8'd0));
    dir_tab.push_back(mk_row(ACT_SPARE, 16'hFFFF, 8'hFF, 1'b1, 1'b1, 1'b0, KIND_PRG, 8'd0));
    dir_tab.push_back(mk_row(ACT_WRITE, 16'hA001, 8'hFF, 1'b0, 1'b1, 1'b0, KIND_PRG, 8'd0));
    dir_tab.push_back(mk_row(ACT_WRITE, 16'hA000, 8'hFF, 1'b0, 1'b1, 1'b1, KIND_MIRROR, 8'd1));
    dir_tab.push_back(mk_row(ACT_WRITE, 16'hBFFE, 8'h00, 1'b1, 1'b1, 1'b1, KIND_MIRROR, 8'd0));
    dir_tab.push_back(mk_row(ACT_WRITE, 16'hC001, 8'h00, 1'b0, 1'b1, 1'b0, KIND_PRG, 8'd0));
    dir_tab.push_back(mk_row(ACT_WRITE, 16'hC000, 8'h00, 1'b0, 1'b1, 1'b0, KIND_PRG, 8'd0));
    dir_tab.push_back(mk_row(ACT_TICK, 16'h0000, 8'h00, 1'b0, 1'b1, 1'b1, KIND_IRQ, 8'd0));
    dir_tab.push_back(mk_row(ACT_TICK, 16'hFFFF, 8'hFF, 1'b1, 1'b1, 1'b0, KIND_PRG, 8'd0));
    dir_tab.push_back(mk_row(ACT_TICK, 16'h0000, 8'h00, 1'b0, 1'b1, 1'b1, KIND_IRQ, 8'd0));
    dir_tab.push_back(mk_row(ACT_WRITE, 16'hDFFE, 8'h02, 1'b0, 1'b1, 1'b0, KIND_PRG, 8'd0));
    dir_tab.push_back(mk_row(ACT_TICK, 16'h1234, 8'h55, 1'b0, 1'b0, 1'b0, KIND_PRG, 8'd0));
    dir_tab.push_back(mk_row(ACT_TICK, 16'hEDCB, 8'hAA, 1'b0, 1'b0, 1'b0, KIND_PRG, 8'd0));
    dir_tab.push_back(mk_row(ACT_TICK, 16'h0000, 8'h00, 1'b0, 1'b0, 1'b0, KIND_PRG, 8'd0));
    dir_tab.push_back(mk_row(ACT_WRITE, 16'hE000, 8'h00, 1'b0, 1'b1, 1'b0, KIND_PRG, 8'd0));
    dir_tab.push_back(mk_row(ACT_WRITE, 16'hFFFF, 8'hFF, 1'b0, 1'b1, 1'b0, KIND_PRG, 8'd0));
    dir_tab.push_back(mk_row(ACT_WRITE, 16'h8000, 8'hC0, 1'b0, 1'b0, 1'b0, KIND_PRG, 8'd0));
    dir_tab.push_back(mk_row(ACT_WRITE, 16'h8001, 8'hFF, 1'b0, 1'b0, 1'b0, KIND_PRG, 8'd0));
    dir_tab.push_back(mk_row(ACT_WRITE, 16'h9FFE, 8'h03, 1'b0, 1'b0, 1'b0, KIND_PRG, 8'd0));
    dir_tab.push_back(mk_row(ACT_WRITE, 16'h9FFF, 8'h00, 1'b0, 1'b0, 1'b0, KIND_PRG, 8'd0));
    dir_tab.push_back(mk_row(ACT_WRITE, 16'h8000, 8'h46, 1'b0, 1'b0, 1'b0, KIND_PRG, 8'd0));
    dir_tab.push_back(mk_row(ACT_WRITE, 16'h8001, 8'hFF, 1'b0, 1'b0, 1'b0, KIND_PRG, 8'd0));
    dir_tab.push_back(mk_row(ACT_WRITE, 16'h8000, 8'h87, 1'b0, 1'b0, 1'b0, KIND_PRG, 8'd0));
    dir_tab.push_back(mk_row(ACT_WRITE, 16'h8001, 8'h80, 1'b0, 1'b0, 1'b0, KIND_PRG, 8'd0));
    dir_tab.push_back(mk_row(ACT_REPORT, 16'hFFFF, 8'hFF, 1'b1, 1'b0, 1'b0, KIND_PRG, 8'd0));
    foreach (dir_tab[i])
      send_item(dir_tab[i].act, dir_tab[i].addr, dir_tab[i].val, dir_tab[i].vb,
                dir_tab[i].pinned, dir_tab[i].n_pin, dir_tab[i].pin);

    // Random phases, one mapper setting each: smallest bank count with
    // four-screen, largest without, all low bits set, then a random count.
    // The second phase runs with no random sender gaps.
    for (int phase = 0; phase < 4; phase++) begin
      wait_quiet();
      case (phase)
        0:       begin cnt = 9'd4;   fs = 1'b1; end
        1:       begin cnt = 9'd256; fs = 1'b0; end
        2:       begin cnt = 9'd255; fs = 1'b1; end
        default: begin cnt = 9'($urandom_range(4, 256)); fs = 1'b0; end
      endcase
      set_reg(CFG_PRG_COUNT, cnt);
      set_reg(CFG_FOUR_SCREEN, {8'd0, fs});
      steady = (phase == 1);
      goal   = item_count + PHASE_ITEMS;
      while (item_count < goal) begin
        // Now and then hold the sender until the mapper has caught up
        if ($urandom_range(0, 99) < 2) wait_quiet();
        pick = $urandom_range(0, 99);
        v    = 8'($urandom);
        if (pick < 28) begin
          // Select a bank register, then fill it
          issue(ACT_WRITE, reg_addr(REG_BANK_SEL), v, 1'($urandom));
          issue(ACT_WRITE, reg_addr(REG_BANK_DATA), 8'($urandom), 1'($urandom));
        end else if (pick < 33) begin
          issue(ACT_WRITE, reg_addr(REG_BANK_SEL), v, 1'($urandom));
        end else if (pick < 58) begin
          issue(ACT_TICK, 16'($urandom), v, $urandom_range(0, 9) == 0);
        end else if (pick < 68) begin
          // Keep counts small so that IRQs come often
          sub = $urandom_range(0, 99);
          if ($urandom_range(0, 3) != 0) v = 8'($urandom_range(0, 4));
          if (sub < 35)      issue(ACT_WRITE, reg_addr(REG_IRQ_COUNT), v, 1'($urandom));
          else if (sub < 65) issue(ACT_WRITE, reg_addr(REG_IRQ_RELOAD), v, 1'($urandom));
          else if (sub < 85) issue(ACT_WRITE, reg_addr(REG_IRQ_ON), v, 1'($urandom));
          else               issue(ACT_WRITE, reg_addr(REG_IRQ_OFF), v, 1'($urandom));
        end else if (pick < 76) begin
          issue(ACT_WRITE, reg_addr(REG_MIRROR), v, 1'($urandom));
        end else if (pick < 82) begin
          issue(ACT_REPORT, 16'($urandom), v, 1'($urandom));
        end else begin
          // Noise: any action, any address
          issue(2'($urandom_range(0, 3)), 16'($urandom), v, 1'($urandom));
        end
      end
    end

    wait_quiet();
    $display("Checked %0d mapper items (%0d ignored) and %0d result words, %0d of them IRQ.",
             item_count, ignored_count, word_count, irq_words);
    $display("Program bank counts 32, 4, 256, 255 and %0d; four-screen both off and on.",
             sh_prg_count);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[files.f]
hdl/brm_pkg.sv
hdl/brm_ctrl.sv
hdl/brm_dp.sv
hdl/banked_rom_mapper_scanline_irq.sv
bench/banked_rom_mapper_scanline_irq_tb.sv
